>>> rtl/mcddt_pkg.sv
// Shared types, register and operation codes and helpers for the dart throwing unit.
// Used by every module of the block; depends on nothing.
package mcddt_pkg;

    localparam int DEF_MAX_CLASSES = 4;
    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_COORD_BITS  = 16;

    localparam int NUM_CLS = 4;
    localparam int CLS_W   = 2;
    localparam int CRD_W   = 16;
    localparam int CNT_W   = 16;
    localparam int REM_W   = 8;

    typedef logic [3:0][63:0] rad_rows_t;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_CLASSES = 3'd0,
        CFG_RADIUS0 = 3'd1,
        CFG_RADIUS1 = 3'd2,
        CFG_RADIUS2 = 3'd3,
        CFG_RADIUS3 = 3'd4,
        CFG_TARGETS = 3'd5
    } cfg_idx_t;

    // Operation carried in tuser of an input word
    typedef enum logic [1:0] {
        OP_CAND  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_PRIME,
        ST_EVAL,
        ST_PURGE,
        ST_INSERT,
        ST_ORDER,
        ST_CLEAR,
        ST_READ,
        ST_RESP
    } state_t;

    // One stored sample as it travels round the ring
    typedef struct packed {
        logic             live;
        logic             conf;
        logic [CLS_W-1:0] cls;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
    } sample_t;

    function automatic logic [15:0] field16(logic [63:0] w, logic [1:0] k);
        return w[16*k +: 16];
    endfunction

    function automatic logic [15:0] radius(rad_rows_t rows, logic [1:0] i, logic [1:0] j);
        return field16(rows[i], j);
    endfunction

endpackage

>>> rtl/mcddt_cell.sv
// One cell of the sample ring: holds a single stored sample.
// Depends on mcddt_pkg for the sample type.
module mcddt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               shift_en,
    input  mcddt_pkg::sample_t d_in,
    output mcddt_pkg::sample_t q
);

    mcddt_pkg::sample_t q_reg;

    // Take the neighbour's sample on each shift; reset frees the slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.live <= 1'b0;
            q_reg.conf <= 1'b0;
        end else if (shift_en) begin
            q_reg <= d_in;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/mcddt_dist.sv
// Distance unit at the ring tail: squares registered, then compared against radius squared.
// Depends on mcddt_pkg for the sample type and widths.
module mcddt_dist (
    input  logic                         aclk,
    input  logic                         load,
    input  mcddt_pkg::sample_t           probe,
    input  logic [mcddt_pkg::CRD_W-1:0]  cand_x,
    input  logic [mcddt_pkg::CRD_W-1:0]  cand_y,
    input  logic [15:0]                  rad,
    output logic                         hit
);

    logic [mcddt_pkg::CRD_W-1:0]   dx, dy;
    logic [2*mcddt_pkg::CRD_W-1:0] dx2_reg, dy2_reg;
    logic [31:0]                   r2_reg;
    logic [2*mcddt_pkg::CRD_W:0]   sum;

    assign dx = (probe.x > cand_x) ? probe.x - cand_x : cand_x - probe.x;
    assign dy = (probe.y > cand_y) ? probe.y - cand_y : cand_y - probe.y;

    // Square the offsets and the radius of the probed sample
    always_ff @(posedge aclk) begin
        if (load) begin
            dx2_reg <= dx * dx;
            dy2_reg <= dy * dy;
            r2_reg  <= rad * rad;
        end
    end

    assign sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign hit = sum < {1'b0, r2_reg};

endmodule

>>> rtl/multi_class_disk_dart_throwing_unit.sv
// Multi-class dart throwing unit; one item in work at a time. An accepted candidate passes
// the class preparation steps, a priming step, a ring turn to test conflicts, one to purge
// and find a free slot, one to insert, then the order steps before its result is valid;
// a rejected one stops after the conflict turn, or after the purge turn when the store is full.
// A slot read or a clear takes a ring turn; a candidate after the run is done, an unknown op
// or an out-of-range read goes straight to the result. s_tready rises the cycle after the
// result loads; a result still waiting holds the block until it is taken.
// Synchronous active-low reset frees every slot, zeroes fills and counters, restores
// identity class order and the register defaults; the block is ready right after.
module multi_class_disk_dart_throwing_unit #(
    parameter int MAX_CLASSES = mcddt_pkg::DEF_MAX_CLASSES,
    parameter int CAPACITY    = mcddt_pkg::DEF_CAPACITY,
    parameter int COORD_BITS  = mcddt_pkg::DEF_COORD_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cand_x[15:0], cand_y[31:16], slot_index[39:32]
    input  logic [1:0]  s_tuser,   // op[1:0]
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // accepted[0], chosen_class[2:1], removed_total[10:3],
                                   // run_done[11], entry_valid[12], entry_class[14:13],
                                   // entry_x[30:15], entry_y[46:31], zero[47]
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CMP_W  = (SLOT_W + 1 > 8) ? SLOT_W + 1 : 8;
    localparam logic [15:0] COORD_MASK =
        (COORD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_BITS) - 32'd1);
    localparam logic [SLOT_W-1:0] LAST_T = SLOT_W'(CAPACITY - 1);

    // Configuration registers
    logic [2:0]             classes_reg;
    mcddt_pkg::rad_rows_t   rad_rows_reg;
    logic [63:0]            targets_reg;

    // Run state
    logic [3:0][15:0]       fill_reg;
    logic [3:0][1:0]        order_reg;
    logic [15:0]            fail_reg;
    logic [15:0]            adds_reg;

    mcddt_pkg::state_t      state_reg, state_next;

    // Working registers of the current item
    logic [1:0]             cls_reg;
    logic [15:0]            cx_reg, cy_reg;
    logic [CMP_W-1:0]       idx_reg;
    logic [1:0]             prep_k_reg;
    logic [3:0]             bad_cls_reg;
    logic                   any_reg, bad_reg, found_reg;
    logic [SLOT_W-1:0]      t_reg, free_reg;
    logic [2:0]             ord_i_reg;
    logic [7:0]             rem_reg;
    logic                   acc_reg;
    logic                   ent_valid_reg;
    logic [1:0]             ent_cls_reg;
    logic [15:0]            ent_x_reg, ent_y_reg;

    // Result register
    logic                   m_valid_reg;
    logic [47:0]            m_data_reg;

    // Ring of cells
    mcddt_pkg::sample_t     cell_q [CAPACITY];
    mcddt_pkg::sample_t     cell_d [CAPACITY];
    mcddt_pkg::sample_t     tail, head_in, probe;
    logic                   shift_en, dist_load, hit;
    logic [SLOT_W-1:0]      home;
    logic                   last_t;

    logic [2:0]             n_act;
    logic [17:0]            lim_sum;
    logic [15:0]            lim;
    logic                   run_done;
    logic                   in_acc;
    logic [1:0]             cmp_a, cmp_b;
    logic                   fill_gt;
    logic [31:0]            prod_ab, prod_ba;
    logic                   tail_hit;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == mcddt_pkg::ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Active classes and run limit
    always_comb begin
        if (classes_reg == 3'd0) begin
            n_act = 3'd1;
        end else if (32'(classes_reg) > MAX_CLASSES) begin
            n_act = 3'(MAX_CLASSES);
        end else begin
            n_act = classes_reg;
        end
        lim_sum = '0;
        for (int k = 0; k < mcddt_pkg::NUM_CLS; k++) begin
            if (3'(k) < n_act) begin
                lim_sum = lim_sum + 18'(mcddt_pkg::field16(targets_reg, 2'(k)));
            end
        end
        lim      = (lim_sum > 18'hFFFF) ? 16'hFFFF : lim_sum[15:0];
        run_done = (adds_reg >= lim) || (fail_reg >= lim);
    end

    // Shared fill comparison: fill(a) > fill(b) by cross-multiplication
    always_comb begin
        cmp_a = cls_reg;
        cmp_b = (state_reg == mcddt_pkg::ST_PREP) ? prep_k_reg : order_reg[ord_i_reg[1:0]];
        prod_ab = fill_reg[cmp_a] * mcddt_pkg::field16(targets_reg, cmp_b);
        prod_ba = fill_reg[cmp_b] * mcddt_pkg::field16(targets_reg, cmp_a);
        fill_gt = prod_ab > prod_ba;
    end

    // Ring wiring
    assign tail   = cell_q[CAPACITY-1];
    assign home   = LAST_T - t_reg;
    assign last_t = (t_reg == LAST_T);

    always_comb begin
        head_in = tail;
        unique case (state_reg)
            mcddt_pkg::ST_EVAL: begin
                head_in.conf = tail.live && hit;
            end
            mcddt_pkg::ST_PURGE: begin
                head_in.live = tail.live && !tail.conf;
                head_in.conf = 1'b0;
            end
            mcddt_pkg::ST_INSERT: begin
                if (home == free_reg) begin
                    head_in.live = 1'b1;
                    head_in.conf = 1'b0;
                    head_in.cls  = cls_reg;
                    head_in.x    = cx_reg;
                    head_in.y    = cy_reg;
                end
            end
            mcddt_pkg::ST_CLEAR: begin
                head_in.live = 1'b0;
                head_in.conf = 1'b0;
            end
            default: begin
                head_in = tail;
            end
        endcase
    end

    assign shift_en = (state_reg == mcddt_pkg::ST_EVAL)   ||
                      (state_reg == mcddt_pkg::ST_PURGE)  ||
                      (state_reg == mcddt_pkg::ST_INSERT) ||
                      (state_reg == mcddt_pkg::ST_CLEAR)  ||
                      (state_reg == mcddt_pkg::ST_READ);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_d[g] = head_in;
            end else begin : g_body
                assign cell_d[g] = cell_q[g-1];
            end
            mcddt_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (cell_d[g]),
                .q        (cell_q[g])
            );
        end
    endgenerate

    // Probe the tail before the first shift, then the sample behind it
    assign dist_load = (state_reg == mcddt_pkg::ST_PRIME) || (state_reg == mcddt_pkg::ST_EVAL);
    assign probe     = (state_reg == mcddt_pkg::ST_PRIME) ? cell_q[CAPACITY-1]
                                                          : cell_q[CAPACITY-2];

    mcddt_dist u_dist (
        .aclk   (aclk),
        .load   (dist_load),
        .probe  (probe),
        .cand_x (cx_reg),
        .cand_y (cy_reg),
        .rad    (mcddt_pkg::radius(rad_rows_reg, probe.cls, cls_reg)),
        .hit    (hit)
    );

    assign tail_hit = tail.live && hit;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mcddt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (s_tuser)
                        mcddt_pkg::OP_CAND:  state_next = run_done ? mcddt_pkg::ST_RESP
                                                                   : mcddt_pkg::ST_PREP;
                        mcddt_pkg::OP_CLEAR: state_next = mcddt_pkg::ST_CLEAR;
                        mcddt_pkg::OP_READ: begin
                            state_next = (CMP_W'(s_tdata[39:32]) < CMP_W'(CAPACITY))
                                       ? mcddt_pkg::ST_READ : mcddt_pkg::ST_RESP;
                        end
                        default: state_next = mcddt_pkg::ST_RESP;
                    endcase
                end
            end
            mcddt_pkg::ST_PREP: begin
                if (prep_k_reg == 2'(mcddt_pkg::NUM_CLS - 1)) begin
                    state_next = mcddt_pkg::ST_PRIME;
                end
            end
            mcddt_pkg::ST_PRIME: state_next = mcddt_pkg::ST_EVAL;
            mcddt_pkg::ST_EVAL: begin
                if (last_t) begin
                    state_next = ((any_reg || tail_hit) &&
                                  (bad_reg || (tail_hit && bad_cls_reg[tail.cls])))
                               ? mcddt_pkg::ST_RESP : mcddt_pkg::ST_PURGE;
                end
            end
            mcddt_pkg::ST_PURGE: begin
                if (last_t) begin
                    state_next = (found_reg || !(tail.live && !tail.conf))
                               ? mcddt_pkg::ST_INSERT : mcddt_pkg::ST_RESP;
                end
            end
            mcddt_pkg::ST_INSERT: begin
                if (last_t) begin
                    state_next = mcddt_pkg::ST_ORDER;
                end
            end
            mcddt_pkg::ST_ORDER: begin
                if (ord_i_reg >= n_act || !fill_gt) begin
                    state_next = mcddt_pkg::ST_RESP;
                end
            end
            mcddt_pkg::ST_CLEAR, mcddt_pkg::ST_READ: begin
                if (last_t) begin
                    state_next = mcddt_pkg::ST_RESP;
                end
            end
            mcddt_pkg::ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = mcddt_pkg::ST_IDLE;
                end
            end
            default: state_next = mcddt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcddt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            classes_reg  <= 3'd1;
            rad_rows_reg <= '0;
            targets_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mcddt_pkg::CFG_CLASSES: classes_reg     <= cfg_data[2:0];
                mcddt_pkg::CFG_RADIUS0: rad_rows_reg[0] <= cfg_data;
                mcddt_pkg::CFG_RADIUS1: rad_rows_reg[1] <= cfg_data;
                mcddt_pkg::CFG_RADIUS2: rad_rows_reg[2] <= cfg_data;
                mcddt_pkg::CFG_RADIUS3: rad_rows_reg[3] <= cfg_data;
                mcddt_pkg::CFG_TARGETS: targets_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Run state: fills, class order and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < mcddt_pkg::NUM_CLS; k++) begin
                fill_reg[k]  <= '0;
                order_reg[k] <= 2'(k);
            end
            fail_reg <= '0;
            adds_reg <= '0;
        end else begin
            if (in_acc && s_tuser == mcddt_pkg::OP_CLEAR) begin
                for (int k = 0; k < mcddt_pkg::NUM_CLS; k++) begin
                    fill_reg[k]  <= '0;
                    order_reg[k] <= 2'(k);
                end
                fail_reg <= '0;
                adds_reg <= '0;
            end
            // Count a failure on rejection or on a full store
            if ((state_reg == mcddt_pkg::ST_EVAL || state_reg == mcddt_pkg::ST_PURGE) &&
                state_next == mcddt_pkg::ST_RESP && fail_reg != 16'hFFFF) begin
                fail_reg <= fail_reg + 16'd1;
            end
            // Note the add once the sample is in place
            if (state_reg == mcddt_pkg::ST_INSERT && last_t) begin
                if (fill_reg[cls_reg] != 16'hFFFF) begin
                    fill_reg[cls_reg] <= fill_reg[cls_reg] + 16'd1;
                end
                if (adds_reg != 16'hFFFF) begin
                    adds_reg <= adds_reg + 16'd1;
                end
                fail_reg <= '0;
            end
            // Bubble the chosen class down the order, one step a cycle
            if (state_reg == mcddt_pkg::ST_ORDER && ord_i_reg < n_act && fill_gt) begin
                order_reg[ord_i_reg[1:0]]         <= order_reg[ord_i_reg[1:0] - 2'd1];
                order_reg[ord_i_reg[1:0] - 2'd1]  <= order_reg[ord_i_reg[1:0]];
            end
        end
    end

    // Working registers of the item in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            found_reg <= 1'b0;
            t_reg     <= '0;
        end else begin
            unique case (state_reg)
                mcddt_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        cls_reg       <= order_reg[0];
                        cx_reg        <= s_tdata[15:0] & COORD_MASK;
                        cy_reg        <= s_tdata[31:16] & COORD_MASK;
                        idx_reg       <= CMP_W'(s_tdata[39:32]);
                        prep_k_reg    <= '0;
                        any_reg       <= 1'b0;
                        bad_reg       <= 1'b0;
                        found_reg     <= 1'b0;
                        t_reg         <= '0;
                        ord_i_reg     <= 3'd1;
                        rem_reg       <= '0;
                        acc_reg       <= 1'b0;
                        ent_valid_reg <= 1'b0;
                        ent_cls_reg   <= '0;
                        ent_x_reg     <= '0;
                        ent_y_reg     <= '0;
                        // Only a live candidate reports a class
                        if (s_tuser != mcddt_pkg::OP_CAND || run_done) begin
                            cls_reg <= '0;
                        end
                    end
                end
                mcddt_pkg::ST_PREP: begin
                    // A conflict with class k blocks the add when k is not the smaller disk
                    // or is filled less than the chosen class
                    bad_cls_reg[prep_k_reg] <=
                        (mcddt_pkg::radius(rad_rows_reg, prep_k_reg, prep_k_reg) >=
                         mcddt_pkg::radius(rad_rows_reg, cls_reg, cls_reg)) || fill_gt;
                    prep_k_reg <= prep_k_reg + 2'd1;
                end
                mcddt_pkg::ST_EVAL: begin
                    if (tail_hit) begin
                        any_reg <= 1'b1;
                        if (bad_cls_reg[tail.cls]) begin
                            bad_reg <= 1'b1;
                        end
                    end
                    t_reg <= last_t ? '0 : t_reg + 1'b1;
                end
                mcddt_pkg::ST_PURGE: begin
                    if (tail.live && tail.conf && rem_reg != 8'hFF) begin
                        rem_reg <= rem_reg + 8'd1;
                    end
                    // Slots pass highest first, so the last free one seen is the lowest
                    if (!(tail.live && !tail.conf)) begin
                        free_reg  <= home;
                        found_reg <= 1'b1;
                    end
                    t_reg <= last_t ? '0 : t_reg + 1'b1;
                end
                mcddt_pkg::ST_INSERT: begin
                    acc_reg <= 1'b1;
                    t_reg   <= last_t ? '0 : t_reg + 1'b1;
                end
                mcddt_pkg::ST_ORDER: begin
                    ord_i_reg <= ord_i_reg + 3'd1;
                end
                mcddt_pkg::ST_READ: begin
                    if (CMP_W'(home) == idx_reg && tail.live) begin
                        ent_valid_reg <= 1'b1;
                        ent_cls_reg   <= tail.cls;
                        ent_x_reg     <= tail.x;
                        ent_y_reg     <= tail.y;
                    end
                    t_reg <= last_t ? '0 : t_reg + 1'b1;
                end
                mcddt_pkg::ST_CLEAR: begin
                    t_reg <= last_t ? '0 : t_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Result register: load on completion, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == mcddt_pkg::ST_RESP && (!m_valid_reg || m_tready)) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= {1'b0, ent_y_reg, ent_x_reg, ent_cls_reg, ent_valid_reg, run_done,
                            acc_reg ? rem_reg : 8'd0, cls_reg, acc_reg};
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

>>> sim/tb_multi_class_disk_dart_throwing_unit.sv
// Testbench for the multi-class dart throwing unit: random and directed words against a
// built-in predictor of the store, class fills and run state. Depends on mcddt_pkg and the RTL.
module tb_multi_class_disk_dart_throwing_unit;

    localparam int SLOTS       = 256;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        bit        accepted;
        bit [1:0]  chosen_class;
        bit [7:0]  removed_total;
        bit        run_done;
        bit        entry_valid;
        bit [1:0]  entry_class;
        bit [15:0] entry_x;
        bit [15:0] entry_y;
    } dart_result_t;

    // Predictor of the dart store and queue of the results it owes
    class dart_scoreboard;
        bit            live[SLOTS];
        bit [1:0]      scls[SLOTS];
        bit [15:0]     sx[SLOTS];
        bit [15:0]     sy[SLOTS];
        bit [15:0]     fill[4];
        bit [1:0]      order[4];
        bit [15:0]     fails;
        bit [15:0]     adds;
        bit [2:0]      ncls;
        bit [63:0]     rad[4];
        bit [63:0]     tgt;
        dart_result_t  owed[$];
        int            errors;

        function new();
            ncls = 3'd1;
            tgt = '0;
            foreach (rad[i]) rad[i] = '0;
            errors = 0;
            clear_store();
        endfunction

        function void clear_store();
            foreach (live[i]) begin
                live[i] = 0; scls[i] = 0; sx[i] = 0; sy[i] = 0;
            end
            for (int i = 0; i < 4; i++) begin
                fill[i] = 0;
                order[i] = i[1:0];
            end
            fails = 0;
            adds = 0;
        endfunction

        function void write_reg(mcddt_pkg::cfg_idx_t idx, bit [63:0] val);
            case (idx)
                mcddt_pkg::CFG_CLASSES: ncls = val[2:0];
                mcddt_pkg::CFG_RADIUS0: rad[0] = val;
                mcddt_pkg::CFG_RADIUS1: rad[1] = val;
                mcddt_pkg::CFG_RADIUS2: rad[2] = val;
                mcddt_pkg::CFG_RADIUS3: rad[3] = val;
                mcddt_pkg::CFG_TARGETS: tgt = val;
                default: ;
            endcase
        endfunction

        function int active();
            if (ncls == 0) return 1;
            if (ncls > 4) return 4;
            return ncls;
        endfunction

        function longint unsigned tg(int k);
            return (tgt >> (16 * k)) & 64'hFFFF;
        endfunction

        function longint unsigned rd(int i, int j);
            return (rad[i] >> (16 * j)) & 64'hFFFF;
        endfunction

        function bit run_done();
            longint unsigned s;
            s = 0;
            for (int k = 0; k < active(); k++) s += tg(k);
            if (s > 65535) s = 65535;
            return adds >= s || fails >= s;
        endfunction

        // fill(a) > fill(b) by cross-multiplication
        function bit fill_gt(int a, int b);
            return longint'(fill[a]) * tg(b) > longint'(fill[b]) * tg(a);
        endfunction

        function void record_add(int c);
            bit [1:0] t;
            if (fill[c] != 16'hFFFF) fill[c]++;
            if (adds != 16'hFFFF) adds++;
            fails = 0;
            // bubble the class back through the order while its fill is higher
            for (int i = 1; i < active(); i++) begin
                if (!fill_gt(c, order[i])) break;
                t = order[i-1]; order[i-1] = order[i]; order[i] = t;
            end
        endfunction

        function void throw_dart(bit [15:0] cx, bit [15:0] cy, ref dart_result_t r);
            bit conf[SLOTS];
            int c, nconf, removed, freeslot, k;
            bit ok;
            longint unsigned dx, dy, rr;
            c = order[0];
            r.chosen_class = 2'(c);
            nconf = 0; removed = 0; freeslot = -1; ok = 1;
            for (int i = 0; i < SLOTS; i++) begin
                conf[i] = 0;
                if (live[i]) begin
                    dx = sx[i] > cx ? sx[i] - cx : cx - sx[i];
                    dy = sy[i] > cy ? sy[i] - cy : cy - sy[i];
                    rr = rd(scls[i], c);
                    if (dx * dx + dy * dy < rr * rr) begin
                        conf[i] = 1;
                        nconf++;
                    end
                end
            end
            // every conflict must be of smaller own radius and not lower fill
            for (int i = 0; i < SLOTS && ok; i++) begin
                if (conf[i]) begin
                    k = scls[i];
                    if (rd(k, k) >= rd(c, c) || fill_gt(c, k)) ok = 0;
                end
            end
            if (ok) begin
                for (int i = 0; i < SLOTS; i++) if (conf[i]) begin
                    live[i] = 0;
                    removed++;
                end
                for (int i = 0; i < SLOTS; i++) if (!live[i]) begin
                    freeslot = i;
                    break;
                end
            end
            if (ok && freeslot >= 0) begin
                live[freeslot] = 1; scls[freeslot] = 2'(c);
                sx[freeslot] = cx; sy[freeslot] = cy;
                record_add(c);
                r.accepted = 1;
                r.removed_total = removed > 255 ? 8'd255 : removed[7:0];
            end else if (fails != 16'hFFFF) begin
                fails++;
            end
        endfunction

        function void note_word(mcddt_pkg::op_t op, bit [15:0] cx, bit [15:0] cy,
                                bit [7:0] idx);
            dart_result_t r;
            r = '{default: 0};
            if (op == mcddt_pkg::OP_CAND && !run_done()) begin
                throw_dart(cx, cy, r);
            end else if (op == mcddt_pkg::OP_CLEAR) begin
                clear_store();
            end else if (op == mcddt_pkg::OP_READ && live[idx]) begin
                r.entry_valid = 1; r.entry_class = scls[idx];
                r.entry_x = sx[idx]; r.entry_y = sy[idx];
            end
            r.run_done = run_done();
            owed = {owed, r};
        endfunction

        function void compare(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_word(bit [47:0] d);
            dart_result_t e;
            if (owed.size() == 0) begin
                $error("result word %h with nothing owed", d);
                errors++;
                return;
            end
            e = owed.pop_front();
            compare("accepted", e.accepted, d[0]);
            compare("chosen_class", e.chosen_class, d[2:1]);
            compare("removed_total", e.removed_total, d[10:3]);
            compare("run_done", e.run_done, d[11]);
            compare("entry_valid", e.entry_valid, d[12]);
            compare("entry_class", e.entry_class, d[14:13]);
            compare("entry_x", e.entry_x, d[30:15]);
            compare("entry_y", e.entry_y, d[46:31]);
            compare("pad", 0, d[47]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // cand_x[15:0], cand_y[31:16], slot_index[39:32]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // accepted, chosen_class, removed_total, run_done,
                            // entry_valid, entry_class, entry_x, entry_y from bit 0 up

    dart_scoreboard sb = new();
    bit  no_idle;
    int  cycles;

    multi_class_disk_dart_throwing_unit dut (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Watch both channels and the config port at the rising edge
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready)
            sb.write_reg(mcddt_pkg::cfg_idx_t'(cfg_index), cfg_data);
        if (aresetn && s_tvalid && s_tready)
            sb.note_word(mcddt_pkg::op_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
                         s_tdata[39:32]);
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    // Stall the result side at random, but never while no_idle is set
    always @(negedge aclk) m_tready <= no_idle || ($urandom_range(99) >= 34);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_cfg(mcddt_pkg::cfg_idx_t idx, bit [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_word(mcddt_pkg::op_t op, bit [15:0] x, bit [15:0] y, bit [7:0] idx);
        while (!no_idle && $urandom_range(99) < 34) begin
            @(negedge aclk);
            s_tvalid <= 0;
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {idx, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and hold until every owed result has come
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        do @(posedge aclk); while (sb.owed.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic configure(bit [2:0] n, bit [63:0] r0, bit [63:0] r1, bit [63:0] r2,
                             bit [63:0] r3, bit [63:0] t);
        write_cfg(mcddt_pkg::CFG_CLASSES, 64'(n));
        write_cfg(mcddt_pkg::CFG_RADIUS0, r0);
        write_cfg(mcddt_pkg::CFG_RADIUS1, r1);
        write_cfg(mcddt_pkg::CFG_RADIUS2, r2);
        write_cfg(mcddt_pkg::CFG_RADIUS3, r3);
        write_cfg(mcddt_pkg::CFG_TARGETS, t);
        send_word(mcddt_pkg::OP_CLEAR, 0, 0, 0);
    endtask

    function automatic bit [63:0] rand_row();
        bit [63:0] w;
        for (int j = 0; j < 4; j++) w[16*j +: 16] = 16'($urandom_range(16'h0400, 16'h5000));
        return w;
    endfunction

    // Mostly candidates, with reads biased to low slots, rare clears and unknown ops
    task automatic random_words(int count, int cand_pct);
        int roll;
        bit [7:0] idx;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            idx = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(31));
            if (roll < cand_pct)
                send_word(mcddt_pkg::OP_CAND, 16'($urandom), 16'($urandom), 8'($urandom));
            else if (roll < 97)
                send_word(mcddt_pkg::OP_READ, 16'($urandom), 16'($urandom), idx);
            else if (roll < 99)
                send_word(mcddt_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
            else
                send_word(mcddt_pkg::op_t'(2'd3), 16'($urandom), 16'($urandom),
                          8'($urandom));
        end
    endtask

    initial begin
        bit [63:0] t;
        aresetn = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = mcddt_pkg::OP_CAND;
        m_tready = 0;
        no_idle = 0;
        cycles = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Register defaults: zero targets mean the run is done at once
        send_word(mcddt_pkg::OP_CAND, 16'h1234, 16'h4321, 0);
        send_word(mcddt_pkg::OP_READ, 0, 0, 0);
        send_word(mcddt_pkg::op_t'(2'd3), 16'hFFFF, 16'hFFFF, 8'hFF);
        send_word(mcddt_pkg::OP_CLEAR, 0, 0, 0);
        drain();

        // Two classes, small targets: corners, reads at both ends, unknown op
        configure(3'd2, rand_row(), rand_row(), rand_row(), rand_row(), 64'h0010_0010);
        send_word(mcddt_pkg::OP_CAND, 16'h0000, 16'h0000, 0);
        send_word(mcddt_pkg::OP_CAND, 16'hFFFF, 16'hFFFF, 0);
        send_word(mcddt_pkg::OP_CAND, 16'h0000, 16'hFFFF, 0);
        send_word(mcddt_pkg::OP_CAND, 16'hFFFF, 16'h0000, 0);
        send_word(mcddt_pkg::OP_CAND, 16'h0100, 16'h0100, 0);
        send_word(mcddt_pkg::OP_CAND, 16'h8000, 16'h8000, 0);
        send_word(mcddt_pkg::OP_READ, 0, 0, 8'd0);
        send_word(mcddt_pkg::OP_READ, 0, 0, 8'd1);
        send_word(mcddt_pkg::OP_READ, 0, 0, 8'd255);
        send_word(mcddt_pkg::op_t'(2'd3), 16'h5555, 16'hAAAA, 8'h55);
        send_word(mcddt_pkg::OP_CLEAR, 0, 0, 0);
        send_word(mcddt_pkg::OP_READ, 0, 0, 8'd0);
        random_words(140, 60);
        drain();

        // Four classes, random targets (zero allowed); first half without idling
        for (int k = 0; k < 4; k++) t[16*k +: 16] = 16'($urandom_range(60));
        configure(3'd4, rand_row(), rand_row(), rand_row(), rand_row(), t);
        no_idle = 1;
        random_words(150, 65);
        no_idle = 0;
        drain();
        random_words(150, 65);
        // Lower the class count mid-run
        drain();
        write_cfg(mcddt_pkg::CFG_CLASSES, 64'd2);
        random_words(60, 65);
        drain();

        // Class count zero acts as one; zero radii and a limit past capacity fill the store
        configure(3'd0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_0120);
        random_words(300, 92);
        drain();

        // Class count above the maximum, full radii, capped limit
        configure(3'd7, {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}},
                  {4{16'hFFFF}});
        random_words(130, 60);
        drain();

        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

>>> multi_class_disk_dart_throwing_unit.f
rtl/mcddt_pkg.sv
rtl/mcddt_cell.sv
rtl/mcddt_dist.sv
rtl/multi_class_disk_dart_throwing_unit.sv
sim/tb_multi_class_disk_dart_throwing_unit.sv
